### rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Types and codes shared by the double-ended queue and its storage cells.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_PUSH_REAR  = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_REAR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // what one lane of every cell does in a cycle
   typedef enum logic [1:0] {
      LANE_HOLD = 2'd0,
      LANE_SHR  = 2'd1,   // take the left neighbour (cell 0 takes the new value)
      LANE_SHL  = 2'd2,   // take the right neighbour
      LANE_PUT  = 2'd3    // the cell at the fill count takes the new value
   } lane_op_type;

   typedef struct packed {
      lane_op_type fwd_op;
      lane_op_type rev_op;
   } cell_ctrl_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  popped_value;
   } rsp_type;

endpackage

### rtl/core/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One position of the queue: a front-ordered lane and a rear-ordered lane.
// ----------------------------------------------------------------------------
module deq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 4
) (
   input  logic                                clock,
   input  deq_pkg::cell_ctrl_type              ctrl,
   input  logic [CNT_W-1:0]                    count,
   input  logic signed [deq_pkg::DATA_W-1:0]   value,
   input  logic signed [deq_pkg::DATA_W-1:0]   fwd_left,
   input  logic signed [deq_pkg::DATA_W-1:0]   fwd_right,
   input  logic signed [deq_pkg::DATA_W-1:0]   rev_left,
   input  logic signed [deq_pkg::DATA_W-1:0]   rev_right,
   output logic signed [deq_pkg::DATA_W-1:0]   fwd_q,
   output logic signed [deq_pkg::DATA_W-1:0]   rev_q
);

   logic signed [deq_pkg::DATA_W-1:0] fwd_ff, fwd_in;
   logic signed [deq_pkg::DATA_W-1:0] rev_ff, rev_in;
   logic                              here;

   assign here = (count == CNT_W'(INDEX));

   function automatic logic signed [deq_pkg::DATA_W-1:0] lane_next(
      input deq_pkg::lane_op_type             op,
      input logic signed [deq_pkg::DATA_W-1:0] own,
      input logic signed [deq_pkg::DATA_W-1:0] left,
      input logic signed [deq_pkg::DATA_W-1:0] right,
      input logic signed [deq_pkg::DATA_W-1:0] val,
      input logic                              sel
   );
      logic signed [deq_pkg::DATA_W-1:0] nxt;
      unique case (op)
         deq_pkg::LANE_SHR: nxt = left;
         deq_pkg::LANE_SHL: nxt = right;
         deq_pkg::LANE_PUT: nxt = sel ? val : own;
         default:           nxt = own;
      endcase
      return nxt;
   endfunction

   assign fwd_in = lane_next(ctrl.fwd_op, fwd_ff, fwd_left, fwd_right, value, here);
   assign rev_in = lane_next(ctrl.rev_op, rev_ff, rev_left, rev_right, value, here);

   always_ff @(posedge clock) begin
      fwd_ff <= fwd_in;
      rev_ff <= rev_in;
   end

   assign fwd_q = fwd_ff;
   assign rev_q = rev_ff;

endmodule

### rtl/core/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of DEPTH signed 32-bit entries built as a row of cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req_    | in        | req_valid / req_ready | deq_pkg::req_type (kind, value)
//  rsp_    | out       | rsp_valid / rsp_ready | deq_pkg::rsp_type (status, popped_value)
//
// One item per cycle: each item is resolved against the fill count in the
// cycle it is taken; every cell shifts, loads or (if refused) holds in that same cycle.
// The result sits in an output register; a new item is taken whenever that
// register is empty or being drained, so only a stalled rsp_ holds off req_.
// Reset empties the queue at once (fill count to zero); entry data is not
// cleared.
// Front lane keeps the front item at cell 0, rear lane the rear item at cell 0,
// so both pops read a fixed cell.
module circular_deque #(
   parameter int DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  deq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output deq_pkg::rsp_type  rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]                  count_ff, count_in;
   logic                              rsp_valid_ff;
   deq_pkg::rsp_type                  rsp_ff, rsp_in;
   deq_pkg::cell_ctrl_type            ctrl;
   logic                              accept;
   logic                              is_full, is_empty;
   logic signed [deq_pkg::DATA_W-1:0] fwd_q [DEPTH];
   logic signed [deq_pkg::DATA_W-1:0] rev_q [DEPTH];

   assign accept   = req_valid && req_ready;
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      ctrl                = '{fwd_op: deq_pkg::LANE_HOLD, rev_op: deq_pkg::LANE_HOLD};
      count_in            = count_ff;
      rsp_in.status       = deq_pkg::STATUS_DONE;
      rsp_in.popped_value = '0;
      unique case (req_data.kind)
         deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_REAR: begin
            if (is_full) begin
               rsp_in.status = deq_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
               if (req_data.kind == deq_pkg::KIND_PUSH_FRONT) begin
                  ctrl = '{fwd_op: deq_pkg::LANE_SHR, rev_op: deq_pkg::LANE_PUT};
               end else begin
                  ctrl = '{fwd_op: deq_pkg::LANE_PUT, rev_op: deq_pkg::LANE_SHR};
               end
            end
         end
         deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_REAR: begin
            if (is_empty) begin
               rsp_in.status = deq_pkg::STATUS_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
               if (req_data.kind == deq_pkg::KIND_POP_FRONT) begin
                  rsp_in.popped_value = fwd_q[0];
                  ctrl.fwd_op         = deq_pkg::LANE_SHL;
               end else begin
                  rsp_in.popped_value = rev_q[0];
                  ctrl.rev_op         = deq_pkg::LANE_SHL;
               end
            end
         end
         default: begin
            rsp_in.status = deq_pkg::STATUS_DONE;
         end
      endcase
      if (!accept) begin
         ctrl     = '{fwd_op: deq_pkg::LANE_HOLD, rev_op: deq_pkg::LANE_HOLD};
         count_in = count_ff;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [deq_pkg::DATA_W-1:0] fwd_l, fwd_r, rev_l, rev_r;
      if (i == 0) begin : g_first
         assign fwd_l = req_data.value;
         assign rev_l = req_data.value;
      end else begin : g_mid
         assign fwd_l = fwd_q[i-1];
         assign rev_l = rev_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign fwd_r = '0;
         assign rev_r = '0;
      end else begin : g_inner
         assign fwd_r = fwd_q[i+1];
         assign rev_r = rev_q[i+1];
      end
      deq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .count     (count_ff),
         .value     (req_data.value),
         .fwd_left  (fwd_l),
         .fwd_right (fwd_r),
         .rev_left  (rev_l),
         .rev_right (rev_r),
         .fwd_q     (fwd_q[i]),
         .rev_q     (rev_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      accept && is_full && !req_data.kind[1]
      |=> rsp_data.status == deq_pkg::STATUS_FULL && $stable(count_ff))
      else $error("push into full queue not refused");

   a_empty_refused: assert property (@(posedge clock) disable iff (reset)
      accept && is_empty && req_data.kind[1]
      |=> rsp_data.status == deq_pkg::STATUS_EMPTY && rsp_data.popped_value == '0)
      else $error("pop from empty queue not refused");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      accept && !is_full && !req_data.kind[1]
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not grow the queue");

   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'(1) |-> fwd_q[0] == rev_q[0])
      else $error("front and rear lanes disagree on single entry");
`endif

endmodule

### tb/circular_deque_test.sv
// ----------------------------------------------------------------------------
// circular_deque_test
// Self-checking bench for the double-ended queue. Items go in through req_;
// a behavioural copy of the ring predicts each result, and every result
// taken from rsp_ is compared field by field in arrival order. Both sides
// stall in random bursts; the closing phase runs flat out.
// ----------------------------------------------------------------------------
module circular_deque_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 8;
   localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CYCLE_LIMIT = 200000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   deq_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   deq_pkg::rsp_type rsp_data;

   circular_deque #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // shadow of the ring
   logic signed [deq_pkg::DATA_W-1:0] ring_shadow [DEPTH];
   logic [IDX_W-1:0]                  head_shadow  = '0;
   logic [IDX_W-1:0]                  tail_shadow  = '0;
   bit                                empty_shadow = 1'b1;

   deq_pkg::rsp_type due_results[$];
   int               mismatch_count = 0;
   int               cycle_count    = 0;
   bit               idle_on        = 1'b0;
   int               stall_left     = 0;

   function automatic logic [IDX_W-1:0] idx_next(logic [IDX_W-1:0] i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
   endfunction

   // applies one item to the shadow ring and returns the result it should give
   function automatic deq_pkg::rsp_type predict_deque_op(deq_pkg::req_type item);
      deq_pkg::rsp_type res;
      bit               is_push;
      bit               at_front;
      res.status       = deq_pkg::STATUS_DONE;
      res.popped_value = '0;
      is_push  = (item.kind == deq_pkg::KIND_PUSH_FRONT) ||
                 (item.kind == deq_pkg::KIND_PUSH_REAR);
      at_front = (item.kind == deq_pkg::KIND_PUSH_FRONT) ||
                 (item.kind == deq_pkg::KIND_POP_FRONT);
      if (is_push) begin
         if (empty_shadow) begin
            head_shadow    = '0;
            tail_shadow    = '0;
            empty_shadow   = 1'b0;
            ring_shadow[0] = item.value;
         end else if (head_shadow == idx_next(tail_shadow)) begin
            res.status = deq_pkg::STATUS_FULL;
         end else if (at_front) begin
            head_shadow              = idx_prev(head_shadow);
            ring_shadow[head_shadow] = item.value;
         end else begin
            tail_shadow              = idx_next(tail_shadow);
            ring_shadow[tail_shadow] = item.value;
         end
      end else begin
         if (empty_shadow) begin
            res.status = deq_pkg::STATUS_EMPTY;
         end else begin
            res.popped_value = at_front ? ring_shadow[head_shadow] : ring_shadow[tail_shadow];
            if (head_shadow == tail_shadow) begin
               empty_shadow = 1'b1;
               head_shadow  = '0;
               tail_shadow  = '0;
            end else if (at_front) begin
               head_shadow = idx_next(head_shadow);
            end else begin
               tail_shadow = idx_prev(tail_shadow);
            end
         end
      end
      return res;
   endfunction

   task automatic send_item(deq_pkg::kind_type kind,
                            logic signed [deq_pkg::DATA_W-1:0] value);
      deq_pkg::req_type item;
      item.kind  = kind;
      item.value = value;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      due_results.push_back(predict_deque_op(item));
   endtask

   task automatic wait_results_in;
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [deq_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic deq_pkg::kind_type pick_kind(int push_pct);
      bit front;
      front = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < push_pct)
         return front ? deq_pkg::KIND_PUSH_FRONT : deq_pkg::KIND_PUSH_REAR;
      return front ? deq_pkg::KIND_POP_FRONT : deq_pkg::KIND_POP_REAR;
   endfunction

   task automatic test_empty_and_single;
      send_item(deq_pkg::KIND_POP_FRONT, pick_value());
      send_item(deq_pkg::KIND_POP_REAR, $urandom);
      send_item(deq_pkg::KIND_PUSH_FRONT, 32'sh7FFF_FFFF);
      send_item(deq_pkg::KIND_POP_REAR, '0);            // removes the last entry
      send_item(deq_pkg::KIND_PUSH_REAR, 32'sh8000_0000);
      send_item(deq_pkg::KIND_POP_FRONT, -32'sd1);      // last entry again
   endtask

   task automatic test_fill_and_wrap;
      send_item(deq_pkg::KIND_PUSH_REAR, '0);
      send_item(deq_pkg::KIND_PUSH_FRONT, -32'sd1);     // head steps back past zero
      for (int i = 1; i < DEPTH - 1; i++)
         send_item(deq_pkg::KIND_PUSH_REAR, i);
      send_item(deq_pkg::KIND_PUSH_FRONT, 32'sh1234_5678);  // full
      send_item(deq_pkg::KIND_PUSH_REAR, 32'sh5555_5555);   // full
      send_item(deq_pkg::KIND_POP_FRONT, '0);               // head wraps forward
      send_item(deq_pkg::KIND_PUSH_REAR, 32'shAAAA_AAAA);
      send_item(deq_pkg::KIND_POP_FRONT, '0);
      send_item(deq_pkg::KIND_PUSH_REAR, 32'sh0F0F_0F0F);   // tail wraps forward
      send_item(deq_pkg::KIND_POP_REAR, '0);                // tail steps back past zero
      send_item(deq_pkg::KIND_POP_REAR, '0);
   endtask

   // bursts lean towards pushes or pops (or neither) so the ring swings between full and empty
   task automatic test_random_traffic(int items);
      int sent;
      int run_len;
      int push_pct;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(0, 2))
            0:       push_pct = 20;
            1:       push_pct = 50;
            default: push_pct = 80;
         endcase
         idle_on = ($urandom_range(0, 3) != 0);
         run_len = $urandom_range(15, 50);
         for (int i = 0; i < run_len && sent < items; i++) begin
            send_item(pick_kind(push_pct), pick_value());
            sent++;
         end
      end
   endtask

   task automatic test_pause_for_results;
      idle_on = 1'b1;
      for (int i = 0; i < 12; i++)
         send_item(pick_kind(60), pick_value());
      wait_results_in();
      for (int i = 0; i < 12; i++)
         send_item(pick_kind(40), pick_value());
   endtask

   task automatic test_back_to_back(int items);
      idle_on = 1'b0;
      for (int i = 0; i < items; i++)
         send_item(pick_kind(50), pick_value());
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      deq_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $display("%0t: result with none due: status %0d value %0d",
                     $time, rsp_data.status, rsp_data.popped_value);
            mismatch_count++;
         end else begin
            want = due_results.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.popped_value !== want.popped_value) begin
               $display("%0t: popped_value expected %0d actual %0d",
                        $time, want.popped_value, rsp_data.popped_value);
               mismatch_count++;
            end
         end
      end
      if (idle_on && stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("circular_deque verification failed");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_single();
      test_fill_and_wrap();
      test_random_traffic(440);
      test_pause_for_results();
      test_back_to_back(60);
      wait_results_in();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && due_results.size() == 0) begin
         $display("circular_deque verification clean");
      end else begin
         $display("circular_deque verification failed");
      end
      $finish;
   end

endmodule
